>>> src/gpp_pkg.sv
package gpp_pkg;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_DIV,
		ST_PRESS,
		ST_PROJ
	} state_t;

	// Finishing mode of the shared multiply unit
	typedef enum logic [1:0] {
		FIN_DIV,
		FIN_PRESS,
		FIN_VEL
	} fin_mode_t;

	// Command codes
	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_RUN   = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	// Status codes
	localparam logic [1:0] STS_WRITE = 2'd0;
	localparam logic [1:0] STS_RUN   = 2'd1;
	localparam logic [1:0] STS_READ  = 2'd2;

	// Register indexes
	localparam logic [2:0] CFG_WIDTH  = 3'd0;
	localparam logic [2:0] CFG_HEIGHT = 3'd1;
	localparam logic [2:0] CFG_PASSES = 3'd2;
	localparam logic [2:0] CFG_INV_H  = 3'd3;
	localparam logic [2:0] CFG_H_SQ   = 3'd4;

endpackage

>>> src/gpp_mac.sv
module gpp_mac (
	input  logic                     clk,
	input  logic                     mul_en,
	input  logic signed [25:0]       mul_a,
	input  logic signed [16:0]       mul_b,
	input  gpp_pkg::fin_mode_t       fin_mode,
	input  logic signed [25:0]       fin_base,
	output logic signed [23:0]       fin_res
);

	logic signed [42:0] prod_q;
	logic signed [44:0] val;
	logic signed [44:0] rnd;

	// Shared multiplier, product held until the next multiply
	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= mul_a * mul_b;
		end
	end

	// base*2^8 - product, round half up, shift right 10 (pressure) or 8, saturate to 16 (velocity) or 24 bits
	always_comb begin
		val = (45'(fin_base) <<< 8) - 45'(prod_q);
		if (fin_mode == gpp_pkg::FIN_PRESS) begin
			rnd = (val + 45'sd512) >>> 10;
		end else begin
			rnd = (val + 45'sd128) >>> 8;
		end
		unique case (fin_mode)
			gpp_pkg::FIN_VEL: begin
				if (rnd > 45'sd32767) fin_res = 24'sh007FFF;
				else if (rnd < -45'sd32768) fin_res = 24'shFF8000;
				else fin_res = 24'(rnd);
			end
			default: begin
				if (rnd > 45'sd8388607) fin_res = 24'sh7FFFFF;
				else if (rnd < -45'sd8388608) fin_res = 24'sh800000;
				else fin_res = 24'(rnd);
			end
		endcase
	end

endmodule

>>> src/grid_pressure_projection_top.sv
// Word        | Direction | Handshake         | Payload
// command     | in        | start / busy      | cmd, cell_col, cell_row, vel_x_in, vel_y_in
// result      | out       | done (one cycle)  | status, vel_x_out, vel_y_out, pressure_out
// config      | in        | cfg_we            | cfg_index, cfg_data
//
// Write: result the cycle after acceptance, next command then. Read: result registered from the READ state.
// Run: each cell step goes through the one read port of the pressure memory one neighbour a
// cycle and the one shared multiplier. After reset a clearing pass zeroes the velocity and
// pressure stores; busy stays high meanwhile. The receiver cannot stall: done lasts one cycle.
module grid_pressure_projection_top #(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic [1:0]         cmd,
	input  logic [5:0]         cell_col,
	input  logic [5:0]         cell_row,
	input  logic signed [15:0] vel_x_in,
	input  logic signed [15:0] vel_y_in,
	output logic               done,
	output logic [1:0]         status,
	output logic signed [15:0] vel_x_out,
	output logic signed [15:0] vel_y_out,
	output logic signed [23:0] pressure_out
);

	localparam int CW    = $clog2(MAX_COLS);
	localparam int RW    = $clog2(MAX_ROWS);
	localparam int AW    = CW + RW;
	localparam int DEPTH = 1 << AW;

	// Configuration
	logic [6:0]  grid_width_q, grid_height_q;
	logic [7:0]  solver_passes_q;
	logic [15:0] inv_cell_size_q, cell_size_sq_q;

	gpp_pkg::state_t state_q, state_d;
	logic [2:0]    st_q;
	logic [RW-1:0] r_q;
	logic [CW-1:0] c_q;
	logic [7:0]    pass_q;
	logic [AW-1:0] clr_q;
	logic          inside_q;

	logic signed [15:0] t0_q, t1_q;
	logic signed [23:0] pc_q;
	logic signed [25:0] acc_q;

	// Memories
	logic signed [15:0] vx_mem [DEPTH];
	logic signed [15:0] vy_mem [DEPTH];
	logic signed [23:0] dv_mem [DEPTH];
	logic signed [23:0] p_mem  [DEPTH];
	logic signed [15:0] vx_rd_q, vy_rd_q;
	logic signed [23:0] dv_rd_q, p_rd_q;
	logic               vx_we, vy_we, dv_we, p_we;
	logic [AW-1:0]      vx_wa, vy_wa, dv_wa, p_wa, vx_ra, vy_ra, dv_ra, p_ra;
	logic signed [15:0] vx_wd, vy_wd;
	logic signed [23:0] dv_wd, p_wd;

	logic                mul_en;
	logic signed [25:0]  mul_a;
	logic signed [16:0]  mul_b;
	gpp_pkg::fin_mode_t  fin_mode;
	logic signed [25:0]  fin_base;
	logic signed [23:0]  fin_res;

	logic [CW-1:0] wm1, cstart, cend;
	logic [RW-1:0] hm1, rstart, rend;
	logic          accept, in_grid, last_cell, border, last_step;
	logic [AW-1:0] a_in, a_i, a_r, a_l, a_d, a_u;
	logic signed [17:0] dsum;

	// Active grid limits
	always_comb begin
		if (grid_width_q < 7'd3) wm1 = CW'(2);
		else if (grid_width_q > MAX_COLS) wm1 = CW'(MAX_COLS - 1);
		else wm1 = CW'(grid_width_q - 7'd1);
		if (grid_height_q < 7'd3) hm1 = RW'(2);
		else if (grid_height_q > MAX_ROWS) hm1 = RW'(MAX_ROWS - 1);
		else hm1 = RW'(grid_height_q - 7'd1);
	end

	assign busy    = (state_q != gpp_pkg::ST_IDLE);
	assign accept  = start && !busy;
	assign in_grid = (cell_col <= wm1) && (cell_row <= hm1);
	assign a_in    = {RW'(cell_row), CW'(cell_col)};
	assign a_i     = {r_q, c_q};
	assign a_r     = {r_q, CW'(c_q + 1'b1)};
	assign a_l     = {r_q, CW'(c_q - 1'b1)};
	assign a_d     = {RW'(r_q + 1'b1), c_q};
	assign a_u     = {RW'(r_q - 1'b1), c_q};

	// Walk bounds of the current phase
	assign cstart    = (state_q == gpp_pkg::ST_DIV) ? '0 : CW'(1);
	assign rstart    = (state_q == gpp_pkg::ST_DIV) ? '0 : RW'(1);
	assign cend      = (state_q == gpp_pkg::ST_DIV) ? wm1 : CW'(wm1 - 1'b1);
	assign rend      = (state_q == gpp_pkg::ST_DIV) ? hm1 : RW'(hm1 - 1'b1);
	assign last_cell = (c_q == cend) && (r_q == rend);
	assign border    = (r_q == '0) || (c_q == '0) || (r_q == hm1) || (c_q == wm1);
	assign last_step = ((state_q == gpp_pkg::ST_DIV) && (st_q == 3'd3))
	                || ((state_q == gpp_pkg::ST_PRESS) && (st_q == 3'd5))
	                || ((state_q == gpp_pkg::ST_PROJ) && (st_q == 3'd4));

	// Forward differences, neighbours past the edge count as zero
	assign dsum = ((c_q != wm1) ? 18'(vx_rd_q) : 18'sd0) - 18'(t0_q)
	            + ((r_q != hm1) ? 18'(vy_rd_q) : 18'sd0) - 18'(t1_q);

	gpp_mac u_mac (
		.clk      (clk),
		.mul_en   (mul_en),
		.mul_a    (mul_a),
		.mul_b    (mul_b),
		.fin_mode (fin_mode),
		.fin_base (fin_base),
		.fin_res  (fin_res)
	);

	// Next state and memory/unit control
	always_comb begin
		state_d  = state_q;
		vx_we = 1'b0; vy_we = 1'b0; dv_we = 1'b0; p_we = 1'b0;
		vx_wa = a_i; vy_wa = a_i; dv_wa = a_i; p_wa = a_i;
		vx_ra = a_i; vy_ra = a_i; dv_ra = a_i; p_ra = a_i;
		vx_wd = fin_res[15:0]; vy_wd = fin_res[15:0];
		dv_wd = fin_res; p_wd = fin_res;
		mul_en   = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		fin_mode = gpp_pkg::FIN_DIV;
		fin_base = '0;
		unique case (state_q)
			gpp_pkg::ST_CLEAR: begin
				vx_we = 1'b1; vy_we = 1'b1; p_we = 1'b1;
				vx_wa = clr_q; vy_wa = clr_q; p_wa = clr_q;
				vx_wd = '0; vy_wd = '0; p_wd = '0;
				if (&clr_q) state_d = gpp_pkg::ST_IDLE;
			end
			gpp_pkg::ST_IDLE: begin
				vx_ra = a_in; vy_ra = a_in; p_ra = a_in;
				vx_wa = a_in; vy_wa = a_in;
				vx_wd = vel_x_in; vy_wd = vel_y_in;
				if (accept) begin
					unique case (cmd)
						gpp_pkg::CMD_WRITE: begin
							vx_we = in_grid;
							vy_we = in_grid;
						end
						gpp_pkg::CMD_RUN:  state_d = gpp_pkg::ST_DIV;
						gpp_pkg::CMD_READ: state_d = gpp_pkg::ST_READ;
						default: ;
					endcase
				end
			end
			gpp_pkg::ST_READ: state_d = gpp_pkg::ST_IDLE;
			gpp_pkg::ST_DIV: begin
				case (st_q)
					3'd1: begin
						vx_ra = a_r;
						vy_ra = a_d;
					end
					3'd2: begin
						mul_en = 1'b1;
						mul_a  = -26'(dsum);
						mul_b  = {1'b0, inv_cell_size_q};
					end
					3'd3: begin
						dv_we = 1'b1;
						p_we  = border;
						p_wd  = '0;
						if (last_cell) begin
							state_d = (solver_passes_q != 8'd0) ? gpp_pkg::ST_PRESS
							                                    : gpp_pkg::ST_PROJ;
						end
					end
					default: ;
				endcase
			end
			gpp_pkg::ST_PRESS: begin
				case (st_q)
					3'd0: p_ra = a_r;
					3'd1: begin
						p_ra   = a_l;
						mul_en = 1'b1;
						mul_a  = 26'(dv_rd_q);
						mul_b  = {1'b0, cell_size_sq_q};
					end
					3'd2: p_ra = a_d;
					3'd3: p_ra = a_u;
					3'd5: begin
						fin_mode = gpp_pkg::FIN_PRESS;
						fin_base = acc_q;
						p_we     = 1'b1;
						if (last_cell && (pass_q == solver_passes_q - 8'd1)) begin
							state_d = gpp_pkg::ST_PROJ;
						end
					end
					default: ;
				endcase
			end
			gpp_pkg::ST_PROJ: begin
				case (st_q)
					3'd1: p_ra = a_r;
					3'd2: begin
						p_ra   = a_d;
						mul_en = 1'b1;
						mul_a  = 26'(p_rd_q) - 26'(pc_q);
						mul_b  = {1'b0, inv_cell_size_q};
					end
					3'd3: begin
						mul_en   = 1'b1;
						mul_a    = 26'(p_rd_q) - 26'(pc_q);
						mul_b    = {1'b0, inv_cell_size_q};
						fin_mode = gpp_pkg::FIN_VEL;
						fin_base = 26'(t0_q);
						vx_we    = 1'b1;
					end
					3'd4: begin
						fin_mode = gpp_pkg::FIN_VEL;
						fin_base = 26'(t1_q);
						vy_we    = 1'b1;
						if (last_cell) state_d = gpp_pkg::ST_IDLE;
					end
					default: ;
				endcase
			end
			default: state_d = gpp_pkg::ST_IDLE;
		endcase
	end

	// Stores: one write and one registered read each
	always_ff @(posedge clk) begin
		if (vx_we) vx_mem[vx_wa] <= vx_wd;
		vx_rd_q <= vx_mem[vx_ra];
	end

	always_ff @(posedge clk) begin
		if (vy_we) vy_mem[vy_wa] <= vy_wd;
		vy_rd_q <= vy_mem[vy_ra];
	end

	always_ff @(posedge clk) begin
		if (dv_we) dv_mem[dv_wa] <= dv_wd;
		dv_rd_q <= dv_mem[dv_ra];
	end

	always_ff @(posedge clk) begin
		if (p_we) p_mem[p_wa] <= p_wd;
		p_rd_q <= p_mem[p_ra];
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q    <= 7'd64;
			grid_height_q   <= 7'd64;
			solver_passes_q <= 8'd20;
			inv_cell_size_q <= 16'd256;
			cell_size_sq_q  <= 16'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gpp_pkg::CFG_WIDTH:  grid_width_q    <= cfg_data[6:0];
				gpp_pkg::CFG_HEIGHT: grid_height_q   <= cfg_data[6:0];
				gpp_pkg::CFG_PASSES: solver_passes_q <= cfg_data[7:0];
				gpp_pkg::CFG_INV_H:  inv_cell_size_q <= cfg_data;
				gpp_pkg::CFG_H_SQ:   cell_size_sq_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gpp_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= '0;
			r_q      <= '0;
			c_q      <= '0;
			pass_q   <= '0;
			clr_q    <= '0;
			inside_q <= 1'b0;
		end else begin
			if (state_q == gpp_pkg::ST_CLEAR) clr_q <= AW'(clr_q + 1'b1);
			if (accept) inside_q <= in_grid;
			if (state_d != state_q) begin
				st_q   <= '0;
				pass_q <= '0;
				if (state_d == gpp_pkg::ST_DIV) begin
					r_q <= '0;
					c_q <= '0;
				end else begin
					r_q <= RW'(1);
					c_q <= CW'(1);
				end
			end else if (last_step) begin
				st_q <= '0;
				if (last_cell) begin
					r_q    <= rstart;
					c_q    <= cstart;
					pass_q <= pass_q + 8'd1;
				end else if (c_q == cend) begin
					c_q <= cstart;
					r_q <= RW'(r_q + 1'b1);
				end else begin
					c_q <= CW'(c_q + 1'b1);
				end
			end else if (busy && (state_q != gpp_pkg::ST_CLEAR)) begin
				st_q <= st_q + 3'd1;
			end
		end
	end

	// Operand registers
	always_ff @(posedge clk) begin
		if (st_q == 3'd1) begin
			t0_q <= vx_rd_q;
			t1_q <= vy_rd_q;
			pc_q <= p_rd_q;
		end
		if (st_q == 3'd1) acc_q <= 26'(p_rd_q);
		else acc_q <= acc_q + 26'(p_rd_q);
	end

	// Result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done         <= 1'b0;
			status       <= gpp_pkg::STS_WRITE;
			vel_x_out    <= '0;
			vel_y_out    <= '0;
			pressure_out <= '0;
		end else begin
			done         <= 1'b0;
			status       <= gpp_pkg::STS_WRITE;
			vel_x_out    <= '0;
			vel_y_out    <= '0;
			pressure_out <= '0;
			if (accept && (cmd != gpp_pkg::CMD_RUN) && (cmd != gpp_pkg::CMD_READ)) begin
				done <= 1'b1;
			end
			if (state_q == gpp_pkg::ST_READ) begin
				done   <= 1'b1;
				status <= gpp_pkg::STS_READ;
				if (inside_q) begin
					vel_x_out    <= vx_rd_q;
					vel_y_out    <= vy_rd_q;
					pressure_out <= p_rd_q;
				end
			end
			if ((state_q == gpp_pkg::ST_PROJ) && (state_d == gpp_pkg::ST_IDLE)) begin
				done   <= 1'b1;
				status <= gpp_pkg::STS_RUN;
			end
		end
	end

	// Checks
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start)))
		else $error("result word without a command");

	a_pass_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gpp_pkg::ST_PRESS) |-> (pass_q < solver_passes_q))
		else $error("solver pass count overrun");

	a_run_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == gpp_pkg::ST_PRESS) || (state_q == gpp_pkg::ST_DIV)) |=> !done)
		else $error("result word during solve");

endmodule
